// ===== hw/rtl/sdi12_pkg.sv =====
// ----------------------------------------------------------------------------
// SDI-12 line transceiver package
// Shared codes, reset values and the result record of the line transceiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sdi12_pkg;

    // Command codes carried by the func field of an input transaction.
    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_WAKE    = 2'd1,
        FUNC_SEND    = 2'd2,
        FUNC_RELEASE = 2'd3
    } t_func;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_BIT_TICKS     = 2'd0,
        CFG_BREAK_TICKS   = 2'd1,
        CFG_MARKING_TICKS = 2'd2,
        CFG_RX_TIMEOUT    = 2'd3
    } t_cfg_index;

    localparam int unsigned TickW = 16;
    localparam int unsigned CharW = 7;

    localparam logic [TickW-1:0] BitTicksReset    = 16'd833;
    localparam logic [TickW-1:0] BreakTicksReset  = 16'd12500;
    localparam logic [TickW-1:0] MarkingTicksReset = 16'd8500;
    localparam logic [TickW-1:0] RxTimeoutReset   = 16'd20000;
    localparam logic [TickW-1:0] TickMax          = 16'hFFFF;

    // Ten bit periods per transmitted frame; receive completes after bit nine.
    localparam logic [3:0] TxBits = 4'd10;
    localparam logic [3:0] RxDone = 4'd9;

    // One result transaction.
    typedef struct packed {
        logic             line_out;
        logic             line_drive;
        logic             toward_sensor;
        logic             busy_res;
        logic             rx_valid;
        logic [CharW-1:0] rx_char;
        logic             rx_timeout;
        logic             rejected;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/sdi12_line_transceiver.sv =====
// ----------------------------------------------------------------------------
// SDI-12 line transceiver
// Single-wire SDI-12 link with inverted line logic, paced by microsecond ticks.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle: either a microsecond tick
// (func 0, carrying the sampled bus level) or a command (wake break, send a
// character, release the line to listen). Every input transaction produces
// exactly one result transaction, and the whole state update is one short
// pass of logic, so the sustained rate is one item per cycle while the result
// side is not stalled. The result is written at the accepting edge into the
// output register, or into the skid register while the output register is
// held. The two-entry output stage (output register plus skid register) lets
// the block keep accepting while a result waits; the input stall rises only
// when both entries are full. Configuration registers are written through a separate
// valid/ready port that is always ready, and must only be written while no
// transaction is in flight. A wake drives the line high for break_ticks and then low for
// marking_ticks; a character goes out as start, seven data bits LSB first,
// even parity and stop, with a zero bit driven high. Commands given during a
// break, marking, transmit or receive are dropped and flagged as rejected.
`default_nettype none

module sdi12_line_transceiver (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input transaction channel.
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [1:0]                        i_func,
    input  wire logic [sdi12_pkg::CharW-1:0]       i_char_in,
    input  wire logic                              i_line_in,
    // Result transaction channel.
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_line_out,
    output logic                                   o_line_drive,
    output logic                                   o_toward_sensor,
    output logic                                   o_busy_res,
    output logic                                   o_rx_valid,
    output logic [sdi12_pkg::CharW-1:0]            o_rx_char,
    output logic                                   o_rx_timeout,
    output logic                                   o_rejected,
    // Configuration write channel.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [sdi12_pkg::TickW-1:0]       i_cfg_data
);
    import sdi12_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_BREAK  = 3'd1,
        PH_MARK   = 3'd2,
        PH_TX     = 3'd3,
        PH_HOLD   = 3'd4,
        PH_LISTEN = 3'd5,
        PH_RX     = 3'd6
    } t_phase;

    // Configuration registers.
    logic [TickW-1:0] r_bit_ticks;
    logic [TickW-1:0] r_break_ticks;
    logic [TickW-1:0] r_marking_ticks;
    logic [TickW-1:0] r_rx_timeout_ticks;

    // Line state.
    t_phase           r_phase, n_phase;
    logic [TickW-1:0] r_tick_cnt, n_tick_cnt;
    logic [3:0]       r_bit_idx, n_bit_idx;
    logic [9:0]       r_tx_shift, n_tx_shift;
    logic [CharW-1:0] r_rx_shift, n_rx_shift;
    logic             r_driving, n_driving;
    logic [TickW-1:0] r_idle_cnt, n_idle_cnt;

    // Output stage: result register and skid register.
    logic             r_out_valid;
    t_result          r_out;
    logic             r_skid_valid;
    t_result          r_skid;

    t_result          n_result;
    t_func            in_func;
    logic             in_accept;
    logic             out_load;
    logic             busy_now;
    logic             busy_next;
    logic [TickW-1:0] tick_inc;
    logic [TickW-1:0] idle_inc;
    logic [TickW-1:0] period_len;
    logic             period_done;
    logic             parity;
    logic             level;

    assign in_func   = t_func'(i_func);
    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;
    // The result register takes new data whenever it is empty or being drained.
    assign out_load  = !r_out_valid || !i_stall;

    assign busy_now  = (r_phase == PH_BREAK) || (r_phase == PH_MARK) ||
                       (r_phase == PH_TX)    || (r_phase == PH_RX);
    assign busy_next = (n_phase == PH_BREAK) || (n_phase == PH_MARK) ||
                       (n_phase == PH_TX)    || (n_phase == PH_RX);

    // Saturating increments of the period and listening counters.
    assign tick_inc = (r_tick_cnt != TickMax) ? r_tick_cnt + 1'b1 : r_tick_cnt;
    assign idle_inc = (r_idle_cnt != TickMax) ? r_idle_cnt + 1'b1 : r_idle_cnt;

    // Length of the period currently running; the first receive period is half a bit.
    always_comb begin
        unique case (r_phase)
            PH_BREAK: period_len = r_break_ticks;
            PH_MARK:  period_len = r_marking_ticks;
            PH_RX:    period_len = (r_bit_idx == 4'd0) ? {1'b0, r_bit_ticks[TickW-1:1]}
                                                       : r_bit_ticks;
            default:  period_len = r_bit_ticks;
        endcase
    end

    assign period_done = (tick_inc >= period_len);
    assign parity      = ^i_char_in;

    always_comb begin
        n_phase    = r_phase;
        n_tick_cnt = r_tick_cnt;
        n_bit_idx  = r_bit_idx;
        n_tx_shift = r_tx_shift;
        n_rx_shift = r_rx_shift;
        n_driving  = r_driving;
        n_idle_cnt = r_idle_cnt;
        n_result   = '0;

        if (in_func != FUNC_TICK) begin
            if (busy_now) begin
                n_result.rejected = 1'b1;
            end else begin
                unique case (in_func)
                    FUNC_WAKE: begin
                        n_driving  = 1'b1;
                        n_phase    = PH_BREAK;
                        n_tick_cnt = '0;
                    end
                    FUNC_SEND: begin
                        // Stop low, parity and data inverted, start high.
                        n_driving  = 1'b1;
                        n_tx_shift = {1'b0, ~parity, ~i_char_in, 1'b1};
                        n_bit_idx  = '0;
                        n_tick_cnt = '0;
                        n_phase    = PH_TX;
                    end
                    default: begin
                        n_driving  = 1'b0;
                        n_phase    = PH_LISTEN;
                        n_idle_cnt = '0;
                        n_tick_cnt = '0;
                    end
                endcase
            end
        end else begin
            unique case (r_phase)
                PH_BREAK, PH_MARK: begin
                    if (period_done) begin
                        n_tick_cnt = '0;
                        n_phase    = (r_phase == PH_BREAK) ? PH_MARK : PH_HOLD;
                    end else begin
                        n_tick_cnt = tick_inc;
                    end
                end
                PH_TX: begin
                    if (period_done) begin
                        n_tick_cnt = '0;
                        if (r_bit_idx + 1'b1 >= TxBits) begin
                            n_bit_idx = '0;
                            n_phase   = PH_HOLD;
                        end else begin
                            n_bit_idx = r_bit_idx + 1'b1;
                        end
                    end else begin
                        n_tick_cnt = tick_inc;
                    end
                end
                PH_LISTEN: begin
                    // A start bit wins over a timeout on the same tick.
                    if (i_line_in) begin
                        n_phase    = PH_RX;
                        n_tick_cnt = '0;
                        n_bit_idx  = '0;
                        n_rx_shift = '0;
                    end else if (idle_inc >= r_rx_timeout_ticks) begin
                        n_idle_cnt          = '0;
                        n_result.rx_timeout = 1'b1;
                    end else begin
                        n_idle_cnt = idle_inc;
                    end
                end
                PH_RX: begin
                    if (period_done) begin
                        n_tick_cnt = '0;
                        // Data bits sit in periods one to seven; a low line is a one.
                        for (int k = 0; k < CharW; k++) begin
                            if (r_bit_idx == 4'(k + 1) && !i_line_in) begin
                                n_rx_shift[k] = 1'b1;
                            end
                        end
                        if (r_bit_idx >= RxDone) begin
                            n_result.rx_valid = 1'b1;
                            n_result.rx_char  = n_rx_shift;
                            n_bit_idx         = '0;
                            n_phase           = PH_LISTEN;
                            n_idle_cnt        = '0;
                        end else begin
                            n_bit_idx = r_bit_idx + 1'b1;
                        end
                    end else begin
                        n_tick_cnt = tick_inc;
                    end
                end
                default: begin
                    // Idle and holding the line low ignore ticks.
                end
            endcase
        end

        // Level on the pin after this transaction.
        level = 1'b0;
        if (n_driving) begin
            if (n_phase == PH_BREAK) begin
                level = 1'b1;
            end else if (n_phase == PH_TX && n_bit_idx < TxBits) begin
                level = n_tx_shift[n_bit_idx];
            end
        end
        n_result.line_out      = level;
        n_result.line_drive    = n_driving;
        n_result.toward_sensor = n_driving;
        n_result.busy_res      = busy_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks        <= BitTicksReset;
            r_break_ticks      <= BreakTicksReset;
            r_marking_ticks    <= MarkingTicksReset;
            r_rx_timeout_ticks <= RxTimeoutReset;
            r_phase            <= PH_IDLE;
            r_tick_cnt         <= '0;
            r_bit_idx          <= '0;
            r_tx_shift         <= '0;
            r_rx_shift         <= '0;
            r_driving          <= 1'b0;
            r_idle_cnt         <= '0;
            r_out_valid        <= 1'b0;
            r_skid_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_BIT_TICKS:     r_bit_ticks        <= i_cfg_data;
                    CFG_BREAK_TICKS:   r_break_ticks      <= i_cfg_data;
                    CFG_MARKING_TICKS: r_marking_ticks    <= i_cfg_data;
                    CFG_RX_TIMEOUT:    r_rx_timeout_ticks <= i_cfg_data;
                    default:           r_bit_ticks        <= r_bit_ticks;
                endcase
            end

            if (in_accept) begin
                r_phase    <= n_phase;
                r_tick_cnt <= n_tick_cnt;
                r_bit_idx  <= n_bit_idx;
                r_tx_shift <= n_tx_shift;
                r_rx_shift <= n_rx_shift;
                r_driving  <= n_driving;
                r_idle_cnt <= n_idle_cnt;
            end

            // Output stage: the skid entry is always older than a new result.
            if (out_load) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_accept;
                end
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_line_out      = r_out.line_out;
    assign o_line_drive    = r_out.line_drive;
    assign o_toward_sensor = r_out.toward_sensor;
    assign o_busy_res      = r_out.busy_res;
    assign o_rx_valid      = r_out.rx_valid;
    assign o_rx_char       = r_out.rx_char;
    assign o_rx_timeout    = r_out.rx_timeout;
    assign o_rejected      = r_out.rejected;

endmodule

`default_nettype wire

// ===== tb/sv/sdi12_line_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SDI-12 line transceiver checker
// Watches the command, result and register channels of the transceiver, keeps
// its own model of the line state and compares every result it sees.
// ----------------------------------------------------------------------------
module sdi12_line_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_stall,
    input  wire logic [1:0]                  i_func,
    input  wire logic [sdi12_pkg::CharW-1:0] i_char_in,
    input  wire logic                        i_line_in,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_stall,
    input  wire logic                        i_line_out,
    input  wire logic                        i_line_drive,
    input  wire logic                        i_toward_sensor,
    input  wire logic                        i_busy_res,
    input  wire logic                        i_rx_valid,
    input  wire logic [sdi12_pkg::CharW-1:0] i_rx_char,
    input  wire logic                        i_rx_timeout,
    input  wire logic                        i_rejected,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_ready,
    input  wire logic [1:0]                  i_cfg_index,
    input  wire logic [sdi12_pkg::TickW-1:0] i_cfg_data,
    output int                               o_mismatches,
    output int                               o_outstanding
);
    import sdi12_pkg::*;

    typedef enum logic [2:0] {
        LINK_IDLE,
        LINK_BREAK,
        LINK_MARK,
        LINK_TX,
        LINK_HOLD,
        LINK_LISTEN,
        LINK_RX
    } t_link_phase;

    logic [TickW-1:0] bit_len;
    logic [TickW-1:0] break_len;
    logic [TickW-1:0] mark_len;
    logic [TickW-1:0] quiet_len;

    t_link_phase      link_phase;
    logic [TickW-1:0] period_cnt;
    logic [3:0]       bit_pos;
    logic [9:0]       tx_frame;
    logic [CharW-1:0] rx_bits;
    logic             drive_en;
    logic [TickW-1:0] quiet_cnt;

    t_result due_results[$];

    function automatic logic link_busy();
        return link_phase inside {LINK_BREAK, LINK_MARK, LINK_TX, LINK_RX};
    endfunction

    // Start high, data LSB first and even parity with a zero driven high, stop low.
    function automatic logic [9:0] line_frame(input logic [CharW-1:0] c);
        return {1'b0, ~(^c), ~c, 1'b1};
    endfunction

    // The count saturates and is tested after the increment, so a length of
    // zero behaves like one and a shortened length ends the period at once.
    function automatic logic period_over(input logic [TickW-1:0] len);
        if (period_cnt != TickMax) period_cnt++;
        if (period_cnt >= len) begin
            period_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result advance_line(input t_func f, input logic [CharW-1:0] c,
                                             input logic ln);
        t_result          r;
        logic [TickW-1:0] len;
        r = '0;
        if (f != FUNC_TICK) begin
            if (link_busy()) begin
                r.rejected = 1'b1;
            end else if (f == FUNC_WAKE) begin
                drive_en   = 1'b1;
                link_phase = LINK_BREAK;
                period_cnt = '0;
            end else if (f == FUNC_SEND) begin
                drive_en   = 1'b1;
                tx_frame   = line_frame(c);
                bit_pos    = '0;
                period_cnt = '0;
                link_phase = LINK_TX;
            end else begin
                drive_en   = 1'b0;
                link_phase = LINK_LISTEN;
                quiet_cnt  = '0;
                period_cnt = '0;
            end
        end else begin
            case (link_phase)
                LINK_BREAK: if (period_over(break_len)) link_phase = LINK_MARK;
                LINK_MARK:  if (period_over(mark_len)) link_phase = LINK_HOLD;
                LINK_TX: begin
                    if (period_over(bit_len)) begin
                        bit_pos++;
                        if (bit_pos >= TxBits) begin
                            bit_pos    = '0;
                            link_phase = LINK_HOLD;
                        end
                    end
                end
                LINK_LISTEN: begin
                    if (ln) begin
                        link_phase = LINK_RX;
                        period_cnt = '0;
                        bit_pos    = '0;
                        rx_bits    = '0;
                    end else begin
                        if (quiet_cnt != TickMax) quiet_cnt++;
                        if (quiet_cnt >= quiet_len) begin
                            quiet_cnt    = '0;
                            r.rx_timeout = 1'b1;
                        end
                    end
                end
                LINK_RX: begin
                    len = (bit_pos == 4'd0) ? (bit_len >> 1) : bit_len;
                    if (period_over(len)) begin
                        if (bit_pos >= 4'd1 && bit_pos <= 4'd7 && !ln)
                            rx_bits[3'(bit_pos - 4'd1)] = 1'b1;
                        if (bit_pos >= RxDone) begin
                            r.rx_valid = 1'b1;
                            r.rx_char  = rx_bits;
                            bit_pos    = '0;
                            link_phase = LINK_LISTEN;
                            quiet_cnt  = '0;
                        end else begin
                            bit_pos++;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        r.line_out = drive_en && (link_phase == LINK_BREAK ||
                     (link_phase == LINK_TX && bit_pos < TxBits && tx_frame[bit_pos]));
        r.line_drive    = drive_en;
        r.toward_sensor = drive_en;
        r.busy_res      = link_busy();
        return r;
    endfunction

    function automatic int field_diff(input string name, input logic [CharW-1:0] want,
                                      input logic [CharW-1:0] got);
        if (got === want) return 0;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            bit_len    = BitTicksReset;
            break_len  = BreakTicksReset;
            mark_len   = MarkingTicksReset;
            quiet_len  = RxTimeoutReset;
            link_phase = LINK_IDLE;
            period_cnt = '0;
            bit_pos    = '0;
            tx_frame   = '0;
            rx_bits    = '0;
            drive_en   = 1'b0;
            quiet_cnt  = '0;
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_BIT_TICKS:     bit_len   = i_cfg_data;
                    CFG_BREAK_TICKS:   break_len = i_cfg_data;
                    CFG_MARKING_TICKS: mark_len  = i_cfg_data;
                    CFG_RX_TIMEOUT:    quiet_len = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall)
                due_results.push_back(advance_line(t_func'(i_func), i_char_in, i_line_in));
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual %0h",
                             $time, {i_line_out, i_line_drive, i_toward_sensor, i_busy_res,
                                     i_rx_valid, i_rx_char, i_rx_timeout, i_rejected});
                    o_mismatches++;
                end else begin
                    want = due_results.pop_front();
                    o_mismatches += field_diff("line_out", CharW'(want.line_out),
                                               CharW'(i_line_out))
                        + field_diff("line_drive", CharW'(want.line_drive),
                                     CharW'(i_line_drive))
                        + field_diff("toward_sensor", CharW'(want.toward_sensor),
                                     CharW'(i_toward_sensor))
                        + field_diff("busy_res", CharW'(want.busy_res), CharW'(i_busy_res))
                        + field_diff("rx_valid", CharW'(want.rx_valid), CharW'(i_rx_valid))
                        + field_diff("rx_char", want.rx_char, i_rx_char)
                        + field_diff("rx_timeout", CharW'(want.rx_timeout),
                                     CharW'(i_rx_timeout))
                        + field_diff("rejected", CharW'(want.rejected), CharW'(i_rejected));
                end
            end
        end
        o_outstanding = due_results.size();
    end

endmodule

// ===== tb/sv/tb_sdi12_line_transceiver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SDI-12 line transceiver testbench
// Feeds wake, send and listen sequences, microsecond ticks and register writes
// into the transceiver with random handshake gaps; the checker beside the
// block predicts every result and counts the mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_sdi12_line_transceiver;
    import sdi12_pkg::*;

    // Cycles without any transaction on any channel before the run is declared hung.
    localparam int unsigned StuckLimit  = 4000;
    localparam int unsigned RandomItems = 600;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;

    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_func            in_func   = FUNC_TICK;
    logic [CharW-1:0] in_char   = '0;
    logic             in_line   = 1'b0;

    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             line_out;
    logic             line_drive;
    logic             toward_sensor;
    logic             busy_res;
    logic             rx_valid;
    logic [CharW-1:0] rx_char;
    logic             rx_timeout;
    logic             rejected;

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    t_cfg_index       cfg_index = CFG_BIT_TICKS;
    logic [TickW-1:0] cfg_data  = '0;

    int               mismatches;
    int               outstanding;
    int               items_sent   = 0;
    int unsigned      stuck_cycles = 0;
    // While calm is set neither side inserts gaps or stalls.
    logic             calm         = 1'b0;

    // The stimulus keeps its own copy of the timing registers so that the
    // sequences it builds (break plus marking, ten bit periods, a sensor
    // reply) last about as long as the block expects.
    int               bit_period   = int'(BitTicksReset);
    int               break_period = int'(BreakTicksReset);
    int               mark_period  = int'(MarkingTicksReset);
    int               quiet_period = int'(RxTimeoutReset);

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    sdi12_line_transceiver dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_func         (in_func),
        .i_char_in      (in_char),
        .i_line_in      (in_line),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_line_out     (line_out),
        .o_line_drive   (line_drive),
        .o_toward_sensor(toward_sensor),
        .o_busy_res     (busy_res),
        .o_rx_valid     (rx_valid),
        .o_rx_char      (rx_char),
        .o_rx_timeout   (rx_timeout),
        .o_rejected     (rejected),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    sdi12_line_checker chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_func         (in_func),
        .i_char_in      (in_char),
        .i_line_in      (in_line),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_line_out     (line_out),
        .i_line_drive   (line_drive),
        .i_toward_sensor(toward_sensor),
        .i_busy_res     (busy_res),
        .i_rx_valid     (rx_valid),
        .i_rx_char      (rx_char),
        .i_rx_timeout   (rx_timeout),
        .i_rejected     (rejected),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    // The result side stalls at random, like the command side, except in the
    // calm stretch and during reset.
    always @(negedge clk) begin
        out_stall <= rst_n && !calm && ($urandom_range(99) < 7);
    end

    // Any transaction on any channel shows that the run is still moving.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        wait (stuck_cycles >= StuckLimit);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offers one input transaction and returns at the falling edge after it
    // was taken. The valid stays high so back-to-back items need no second
    // assignment in the same step; a gap lowers it first and then waits.
    task automatic send_item(input t_func f, input logic [CharW-1:0] c, input logic ln);
        while (!calm && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= f;
        in_char  <= c;
        in_line  <= ln;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Holds off the command side until every expected result has come back.
    // It always waits for a falling edge before it tests, so two calls never share a step.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    // Register writes happen only with the command channel drained.
    task automatic write_reg(input t_cfg_index idx, input logic [TickW-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BIT_TICKS:     bit_period   = int'(val);
            CFG_BREAK_TICKS:   break_period = int'(val);
            CFG_MARKING_TICKS: mark_period  = int'(val);
            CFG_RX_TIMEOUT:    quiet_period = int'(val);
            default: begin
            end
        endcase
    endtask

    task automatic fill_timing(input logic [TickW-1:0] val);
        write_reg(CFG_BIT_TICKS, val);
        write_reg(CFG_BREAK_TICKS, val);
        write_reg(CFG_MARKING_TICKS, val);
        write_reg(CFG_RX_TIMEOUT, val);
    endtask

    // Short periods keep sequences brief; now and then a longer bit period.
    task automatic shuffle_timing();
        write_reg(CFG_BIT_TICKS,
                  ($urandom_range(9) == 0) ? TickW'($urandom_range(12, 5))
                                           : TickW'($urandom_range(4, 2)));
        write_reg(CFG_BREAK_TICKS, TickW'($urandom_range(12, 1)));
        write_reg(CFG_MARKING_TICKS, TickW'($urandom_range(12, 1)));
        write_reg(CFG_RX_TIMEOUT, TickW'($urandom_range(24, 2)));
    endtask

    // Ticks at a fixed bus level; the character field carries random junk.
    task automatic line_ticks(input int n, input logic ln);
        repeat (n) send_item(FUNC_TICK, CharW'($urandom_range(127)), ln);
    endtask

    task automatic stray_command();
        send_item(t_func'($urandom_range(3, 1)), CharW'($urandom_range(127)),
                  1'($urandom_range(1)));
    endtask

    // Ticks while the block drives the line; an occasional command falls in,
    // which is rejected while busy and taken once the line is held low.
    task automatic busy_ticks(input int n);
        repeat (n) begin
            if ($urandom_range(19) == 0) stray_command();
            send_item(FUNC_TICK, CharW'($urandom_range(127)), 1'($urandom_range(1)));
        end
    endtask

    // A sensor answering on the bus: same inverted framing as a transmit,
    // one bit period per bit.
    task automatic sensor_char(input logic [CharW-1:0] c);
        logic [9:0] levels;
        int         per;
        levels = {1'b0, ~(^c), ~c, 1'b1};
        per    = (bit_period < 1) ? 1 : bit_period;
        for (int b = 0; b < 10; b++) line_ticks(per, levels[b]);
    endtask

    task automatic wake_up();
        send_item(FUNC_WAKE, CharW'($urandom_range(127)), 1'($urandom_range(1)));
        busy_ticks(break_period + mark_period + $urandom_range(2));
    endtask

    task automatic send_char();
        send_item(FUNC_SEND, CharW'($urandom_range(127)), 1'($urandom_range(1)));
        busy_ticks(10 * bit_period + $urandom_range(2));
    endtask

    // Release the line, sit quiet for a while (timeouts may fire), then take
    // a reply of a few characters. Sometimes a command lands right after a
    // start bit, while the block is receiving.
    task automatic hear_reply();
        send_item(FUNC_RELEASE, CharW'($urandom_range(127)), 1'($urandom_range(1)));
        line_ticks($urandom_range(quiet_period + quiet_period / 2), 1'b0);
        repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(7) == 0) begin
                line_ticks(1, 1'b1);
                stray_command();
            end
            sensor_char(CharW'($urandom_range(127)));
            line_ticks($urandom_range(2), 1'b0);
        end
    endtask

    initial begin
        int base;
        int pick;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset timing: ticks on an idle line do nothing, release starts
        // listening, and a release while listening is accepted again.
        send_item(FUNC_TICK, 7'h7F, 1'b1);
        send_item(FUNC_RELEASE, 7'h00, 1'b0);
        send_item(FUNC_TICK, 7'h00, 1'b0);
        send_item(FUNC_RELEASE, 7'h2A, 1'b1);

        // All registers at zero act as one-tick periods. A zero timeout fires
        // on every quiet tick, and a start bit on a tick beats the timeout.
        fill_timing('0);
        line_ticks(2, 1'b0);
        line_ticks(1, 1'b1);
        send_item(FUNC_WAKE, 7'h00, 1'b0);
        line_ticks(10, 1'b0);
        // Send straight from listening, then try to release mid-frame.
        send_item(FUNC_SEND, 7'h00, 1'b0);
        send_item(FUNC_RELEASE, 7'h7F, 1'b1);
        line_ticks(10, 1'b0);
        // Wake from the held-low line, then send the all-ones character.
        send_item(FUNC_WAKE, 7'h7F, 1'b1);
        send_item(FUNC_SEND, 7'h55, 1'b0);
        line_ticks(2, 1'b1);
        send_item(FUNC_SEND, 7'h7F, 1'b1);
        line_ticks(10, 1'b0);

        // Maximum periods, each cut short by a smaller value written while
        // the period runs: it must end as soon as the count reaches it.
        fill_timing(TickMax);
        send_item(FUNC_WAKE, 7'h2A, 1'b0);
        line_ticks(3, 1'b0);
        write_reg(CFG_BREAK_TICKS, 16'd2);
        line_ticks(2, 1'b0);
        write_reg(CFG_MARKING_TICKS, 16'd1);
        line_ticks(1, 1'b0);
        send_item(FUNC_SEND, 7'h55, 1'b1);
        line_ticks(4, 1'b0);
        write_reg(CFG_BIT_TICKS, 16'd2);
        line_ticks(20, 1'b0);

        // Random part: complete wake, command, listen and reply
        // exchanges with random content, plus lone pieces, noise and
        // occasional new timing.
        shuffle_timing();
        base = items_sent;
        while (items_sent - base < RandomItems) begin
            calm <= (items_sent - base >= 300) && (items_sent - base < 450);
            pick = $urandom_range(99);
            if (pick < 45) begin
                wake_up();
                repeat ($urandom_range(3, 1)) send_char();
                hear_reply();
            end else if (pick < 65) begin
                if ($urandom_range(1) == 0) wake_up();
                else send_char();
            end else if (pick < 82) begin
                hear_reply();
            end else if (pick < 93) begin
                repeat ($urandom_range(30, 5)) begin
                    if ($urandom_range(9) < 7)
                        send_item(FUNC_TICK, CharW'($urandom_range(127)),
                                  1'($urandom_range(1)));
                    else
                        stray_command();
                end
            end else begin
                shuffle_timing();
            end
        end
        calm <= 1'b0;

        settle();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sdi12_pkg.sv
hw/rtl/sdi12_line_transceiver.sv
tb/sv/sdi12_line_checker.sv
tb/sv/tb_sdi12_line_transceiver.sv
